// ===== sv/swm_pkg.sv =====
package swm_pkg;

  // Fixed widths of the sample path and the configuration register, and window size bounds
  localparam int DATA_W         = 32;
  localparam int WSZ_W          = 7;
  localparam int WSZ_MIN        = 3;
  localparam int WINDOW_MAX_DEF = 64;

  // APB register map: one 32-bit register, word index in paddr[2]
  localparam int APB_DATA_W = 32;
  localparam int CFG_ADDR_W = 3;
  localparam int REG_IDX_W  = CFG_ADDR_W - 2;

  localparam logic [REG_IDX_W-1:0] REG_WINDOW_SIZE = '0;
  localparam logic [WSZ_W-1:0]     WSZ_RESET       = WSZ_W'(WSZ_MIN);

  // Controller states
  typedef enum logic [3:0] {
    S_IDLE,
    S_LOAD,
    S_OLD,
    S_FIND,
    S_SHIFT_RD,
    S_SHIFT_EV,
    S_MED_HI,
    S_MED_LO,
    S_MED_CALC,
    S_OUT
  } state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic accept;     // latch sample, clear window on start request
    logic fill_wr;    // window filling: append sample, open hole at end
    logic old_rd;     // read the oldest sample from the arrival store
    logic old_wr;     // latch oldest, overwrite it, start sorted scan
    logic find_step;  // advance sorted scan
    logic find_hit;   // oldest located: open hole there
    logic shift_rd;   // read neighbor of the hole
    logic shift_mv;   // move neighbor into the hole
    logic shift_put;  // drop new sample into the hole
    logic med_rd_hi;  // read upper middle entry
    logic med_rd_lo;  // latch upper, read lower middle entry
    logic med_calc;   // form the median
    logic out_load;   // load the output register
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic full;
    logic match;
    logic find_last;
    logic nb_exists;
    logic beyond;
    logic med_due;
    logic out_free;
  } sts_t;

endpackage

// ===== sv/swm_if.sv =====
// Input channel: one sample per transfer
interface swm_in_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [swm_pkg::DATA_W-1:0]    sample;
  logic                                 start_req;

  modport source (output valid, sample, start_req, input ready);
  modport sink   (input valid, sample, start_req, output ready);
endinterface

// Result channel: one median per transfer
interface swm_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [swm_pkg::DATA_W-1:0]    median;

  modport source (output valid, median, input ready);
  modport sink   (input valid, median, output ready);
endinterface

// ===== sv/swm_ram.sv =====
module swm_ram #(
  parameter int WIDTH = swm_pkg::DATA_W,
  parameter int DEPTH = swm_pkg::WINDOW_MAX_DEF
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/swm_ctrl.sv =====
module swm_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  swm_pkg::sts_t sts,
  output swm_pkg::cmd_t cmd
);

  swm_pkg::state_t state_r;
  swm_pkg::state_t state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= swm_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      swm_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = swm_pkg::S_LOAD;
        end
      end
      swm_pkg::S_LOAD: begin
        if (!sts.full) begin
          cmd.fill_wr = 1'b1;
          state_nxt   = swm_pkg::S_SHIFT_RD;
        end else begin
          cmd.old_rd = 1'b1;
          state_nxt  = swm_pkg::S_OLD;
        end
      end
      swm_pkg::S_OLD: begin
        cmd.old_wr = 1'b1;
        state_nxt  = swm_pkg::S_FIND;
      end
      swm_pkg::S_FIND: begin
        if (sts.match || sts.find_last) begin
          cmd.find_hit = 1'b1;
          state_nxt    = swm_pkg::S_SHIFT_RD;
        end else begin
          cmd.find_step = 1'b1;
        end
      end
      swm_pkg::S_SHIFT_RD: begin
        if (sts.nb_exists) begin
          cmd.shift_rd = 1'b1;
          state_nxt    = swm_pkg::S_SHIFT_EV;
        end else begin
          cmd.shift_put = 1'b1;
          state_nxt     = sts.med_due ? swm_pkg::S_MED_HI : swm_pkg::S_IDLE;
        end
      end
      swm_pkg::S_SHIFT_EV: begin
        if (sts.beyond) begin
          cmd.shift_mv = 1'b1;
          state_nxt    = swm_pkg::S_SHIFT_RD;
        end else begin
          cmd.shift_put = 1'b1;
          state_nxt     = sts.med_due ? swm_pkg::S_MED_HI : swm_pkg::S_IDLE;
        end
      end
      swm_pkg::S_MED_HI: begin
        cmd.med_rd_hi = 1'b1;
        state_nxt     = swm_pkg::S_MED_LO;
      end
      swm_pkg::S_MED_LO: begin
        cmd.med_rd_lo = 1'b1;
        state_nxt     = swm_pkg::S_MED_CALC;
      end
      swm_pkg::S_MED_CALC: begin
        cmd.med_calc = 1'b1;
        state_nxt    = swm_pkg::S_OUT;
      end
      swm_pkg::S_OUT: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = swm_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = swm_pkg::S_IDLE;
      end
    endcase
  end

endmodule

// ===== sv/swm_dp.sv =====
module swm_dp #(
  parameter int WINDOW_MAX = swm_pkg::WINDOW_MAX_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  swm_pkg::cmd_t                       cmd,
  output swm_pkg::sts_t                       sts,
  input  logic signed [swm_pkg::DATA_W-1:0]   in_sample,
  input  logic                                in_start,
  input  logic                                cfg_we,
  input  logic [swm_pkg::WSZ_W-1:0]           cfg_wdata,
  output logic [swm_pkg::WSZ_W-1:0]           wsz,
  input  logic                                out_ready,
  output logic                                out_valid,
  output logic signed [swm_pkg::DATA_W-1:0]   out_median
);

  localparam int DW = swm_pkg::DATA_W;
  localparam int AW = $clog2(WINDOW_MAX);
  localparam int CW = $clog2(WINDOW_MAX + 1);
  localparam int EW = (CW > swm_pkg::WSZ_W) ? CW : swm_pkg::WSZ_W;

  // Configuration and window bookkeeping
  logic [swm_pkg::WSZ_W-1:0] wsz_r;
  logic [CW-1:0]             w_r;
  logic [CW-1:0]             w_nxt;
  logic [CW-1:0]             fill_r;
  logic [AW-1:0]             oldest_r;
  logic [AW-1:0]             oldest_nxt;

  // Per-item working registers
  logic signed [DW-1:0] x_r;
  logic signed [DW-1:0] old_r;
  logic signed [DW-1:0] a_r;
  logic signed [DW-1:0] med_r;
  logic signed [DW-1:0] median_r;
  logic                 out_valid_r;
  logic [AW-1:0]        k_r;
  logic [AW-1:0]        h_r;
  logic                 dir_up_r;

  // Store ports
  logic          arr_we;
  logic [AW-1:0] arr_waddr;
  logic [DW-1:0] arr_rdata;
  logic          srt_we;
  logic [DW-1:0] srt_wdata;
  logic [AW-1:0] srt_raddr;
  logic [DW-1:0] srt_rdata;

  logic signed [DW-1:0] q;
  logic [AW-1:0]        nb;
  logic [AW-1:0]        half;
  logic [EW-1:0]        wsz_ext;
  logic [EW-1:0]        w_eff;
  logic signed [DW:0]   pair_sum;

  assign q    = $signed(srt_rdata);
  assign nb   = dir_up_r ? (h_r + AW'(1)) : (h_r - AW'(1));
  assign half = AW'(w_r >> 1);

  // Clamp written window size into [3, WINDOW_MAX]
  always_comb begin
    wsz_ext = EW'(cfg_wdata);
    if (wsz_ext < EW'(swm_pkg::WSZ_MIN)) begin
      w_eff = EW'(swm_pkg::WSZ_MIN);
    end else if (wsz_ext > EW'(WINDOW_MAX)) begin
      w_eff = EW'(WINDOW_MAX);
    end else begin
      w_eff = wsz_ext;
    end
    w_nxt = CW'(w_eff);
  end

  // Ring pointer wraps at the window size
  assign oldest_nxt = ((CW'(oldest_r) + CW'(1)) == w_r) ? '0 : (oldest_r + AW'(1));

  // Arrival store: sample appended while filling, oldest overwritten once full
  assign arr_we    = cmd.fill_wr | cmd.old_wr;
  assign arr_waddr = cmd.fill_wr ? fill_r[AW-1:0] : oldest_r;

  swm_ram #(.WIDTH(DW), .DEPTH(WINDOW_MAX)) u_arr_ram (
    .clk   (clk),
    .we    (arr_we),
    .waddr (arr_waddr),
    .wdata (x_r),
    .raddr (oldest_r),
    .rdata (arr_rdata)
  );

  // Sorted store: hole at h_r moves toward the new sample's place
  assign srt_we    = cmd.shift_mv | cmd.shift_put;
  assign srt_wdata = cmd.shift_mv ? srt_rdata : x_r;

  always_comb begin
    if (cmd.old_wr) begin
      srt_raddr = '0;
    end else if (cmd.find_step) begin
      srt_raddr = k_r + AW'(1);
    end else if (cmd.shift_rd) begin
      srt_raddr = nb;
    end else if (cmd.med_rd_hi) begin
      srt_raddr = half;
    end else begin
      srt_raddr = half - AW'(1);
    end
  end

  swm_ram #(.WIDTH(DW), .DEPTH(WINDOW_MAX)) u_srt_ram (
    .clk   (clk),
    .we    (srt_we),
    .waddr (h_r),
    .wdata (srt_wdata),
    .raddr (srt_raddr),
    .rdata (srt_rdata)
  );

  // Even window: floored mean of the two middle entries
  assign pair_sum = {a_r[DW-1], a_r} + {q[DW-1], q};

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wsz_r       <= swm_pkg::WSZ_RESET;
      w_r         <= CW'(swm_pkg::WSZ_MIN);
      fill_r      <= '0;
      oldest_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        wsz_r    <= cfg_wdata;
        w_r      <= w_nxt;
        fill_r   <= '0;
        oldest_r <= '0;
      end else begin
        if (cmd.accept && in_start) begin
          fill_r   <= '0;
          oldest_r <= '0;
        end
        if (cmd.fill_wr) begin
          fill_r <= fill_r + CW'(1);
        end
        if (cmd.old_wr) begin
          oldest_r <= oldest_nxt;
        end
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      x_r <= in_sample;
    end
    if (cmd.old_wr) begin
      old_r <= $signed(arr_rdata);
      k_r   <= '0;
    end
    if (cmd.find_step) begin
      k_r <= k_r + AW'(1);
    end
    if (cmd.fill_wr) begin
      h_r      <= fill_r[AW-1:0];
      dir_up_r <= 1'b0;
    end else if (cmd.find_hit) begin
      h_r      <= k_r;
      dir_up_r <= (x_r > old_r);
    end else if (cmd.shift_mv) begin
      h_r <= nb;
    end
    if (cmd.med_rd_lo) begin
      a_r <= q;
    end
    if (cmd.med_calc) begin
      med_r <= w_r[0] ? a_r : pair_sum[DW:1];
    end
    if (cmd.out_load) begin
      median_r <= med_r;
    end
  end

  // Status
  assign sts.full      = !(fill_r < w_r);
  assign sts.match     = (q == old_r);
  assign sts.find_last = (CW'(k_r) == (w_r - CW'(1)));
  assign sts.nb_exists = dir_up_r ? ((CW'(h_r) + CW'(1)) < w_r) : (h_r != '0);
  assign sts.beyond    = dir_up_r ? (q < x_r) : (q > x_r);
  assign sts.med_due   = (fill_r == w_r);
  assign sts.out_free  = !out_valid_r || out_ready;

  assign wsz        = wsz_r;
  assign out_valid  = out_valid_r;
  assign out_median = median_r;

endmodule

// ===== sv/sliding_window_median_core.sv =====
// Running median filter over signed 32-bit samples. Each input transfer
// carries one sample and a start flag; a set start flag empties the window
// and the sample becomes the first of a new sequence. The first W-1
// samples of a sequence give no result; each sample after the W-th
// replaces the oldest one, and from the W-th on every sample gives one
// result, the median of the last W samples (odd W: middle value; even W:
// floor of the mean of the two middle values). W is the window_size
// register at byte address 0, clamped to [3, WINDOW_MAX]; writing it
// empties the window, and it may be written only while the block is
// idle. Items are handled one at a time. The sorted store has a single
// read port, so locating the outgoing value scans its entries one by
// one and each entry shifted aside for the new sample is read, then
// written; reading the two middle entries, forming the median and
// loading the output register follow. A finished result sits in an
// output register, so the next sample is accepted while that result
// waits. No clearing pass follows reset.
module sliding_window_median_core #(
  parameter int WINDOW_MAX = swm_pkg::WINDOW_MAX_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  swm_in_if.sink                             in_ch,
  swm_out_if.source                          out_ch,
  input  logic                               cfg_psel,
  input  logic                               cfg_penable,
  input  logic                               cfg_pwrite,
  input  logic [swm_pkg::CFG_ADDR_W-1:0]     cfg_paddr,
  input  logic [swm_pkg::APB_DATA_W-1:0]     cfg_pwdata,
  output logic [swm_pkg::APB_DATA_W-1:0]     cfg_prdata,
  output logic                               cfg_pready
);

  swm_pkg::cmd_t                cmd;
  swm_pkg::sts_t                sts;
  logic                         in_ready;
  logic                         cfg_we;
  logic                         reg_hit;
  logic [swm_pkg::WSZ_W-1:0]    wsz;

  // APB register decode
  assign reg_hit    = (cfg_paddr[swm_pkg::CFG_ADDR_W-1:2] == swm_pkg::REG_WINDOW_SIZE);
  assign cfg_pready = 1'b1;
  assign cfg_we     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready & reg_hit;
  assign cfg_prdata = reg_hit ? {(swm_pkg::APB_DATA_W - swm_pkg::WSZ_W)'(0), wsz} : '0;

  assign in_ch.ready = in_ready;

  swm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  swm_dp #(.WINDOW_MAX(WINDOW_MAX)) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_sample  (in_ch.sample),
    .in_start   (in_ch.start_req),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_pwdata[swm_pkg::WSZ_W-1:0]),
    .wsz        (wsz),
    .out_ready  (out_ch.ready),
    .out_valid  (out_ch.valid),
    .out_median (out_ch.median)
  );

  // A result is never loaded over one still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_ch.valid || out_ch.ready))
    else $error("result register overwritten while still pending");

  // While ready, no store is being modified
  a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.ready |-> !(cmd.fill_wr || cmd.old_wr || cmd.shift_mv || cmd.shift_put))
    else $error("store written while accepting input");

  // One item at a time: an accepted transfer drops ready next cycle
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    else $error("second item accepted before first finished");

  // The median is read only once the window is full
  a_full_window: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.med_rd_hi |-> sts.med_due)
    else $error("median read from an incomplete window");

endmodule
